@@ rtl/core/llsd_pkg.sv @@
// llsd_pkg: shared widths, limits and state codes for the least-loaded dispatcher.
// No dependencies; used by the dispatcher top level.
package llsd_pkg;

  localparam int MaxServers = 16;
  localparam int LoadW      = 32;
  localparam int JobW       = 16;
  localparam int CfgW       = 5;
  localparam int SrvW       = 5;
  localparam int IdxW       = (MaxServers > 1) ? $clog2(MaxServers) : 1;
  localparam int CntW       = $clog2(MaxServers + 1);

  localparam logic [LoadW-1:0] LoadMax      = {LoadW{1'b1}};
  localparam logic [CfgW-1:0]  ActiveReset  = CfgW'(16);

  localparam logic ActClear  = 1'b0;
  localparam logic ActAssign = 1'b1;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StScan   = 3'b010,
    StFinish = 3'b100
  } state_e;

endpackage

@@ rtl/core/least_loaded_server_dispatch.sv @@
// least_loaded_server_dispatch: top level of the least-loaded job dispatcher.
// Depends on llsd_pkg (widths, state codes) and llsd_ram (load store).
// Usage
//   Input channel (in_valid_i / in_stall_o, action_i, job_time_i): one
//   transaction per job or clear. Output channel (out_valid_o / out_stall_i,
//   assigned_server_o, next_server_o): one transaction per input.
//   Configuration: cfg_we_i writes cfg_wdata_i into active_servers; write it
//   only while idle. Zero acts as one server, above MaxServers as MaxServers.
//   An assign runs a scan over the n active servers: a single compare unit
//   walks the loads one RAM read per cycle, keeping best and runner-up, then
//   the finish step writes the saturated load back and forms the next pick.
//   A clear skips the scan and goes straight to the finish step.
//   in_stall_o is high from acceptance until the result is loaded into the
//   output register, so a new item is not taken until the last one is
//   through; a new transaction is taken while a result waits there.
//   If the receiver stalls, the finish step holds until the output register
//   is free, so nothing is lost or overwritten.
//   Reset: all loads read as zero (per-entry valid bits cleared at once),
//   active_servers is 16, both channels idle. No clearing pass is needed.
module least_loaded_server_dispatch (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       action_i,
  input  logic [llsd_pkg::JobW-1:0]  job_time_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [llsd_pkg::SrvW-1:0]  assigned_server_o,
  output logic [llsd_pkg::SrvW-1:0]  next_server_o,
  input  logic                       cfg_we_i,
  input  logic [llsd_pkg::CfgW-1:0]  cfg_wdata_i
);

  localparam int MaxS  = llsd_pkg::MaxServers;
  localparam int IdxW  = llsd_pkg::IdxW;
  localparam int CntW  = llsd_pkg::CntW;
  localparam int LoadW = llsd_pkg::LoadW;
  localparam int SrvW  = llsd_pkg::SrvW;

  llsd_pkg::state_e state_q, state_d;

  logic [llsd_pkg::CfgW-1:0] active_q;
  logic [CntW-1:0]           n_eff;
  logic [CntW-1:0]           n_q;
  logic                      action_q;
  logic [llsd_pkg::JobW-1:0] job_q;

  // scan pointers: read issue index and returning-data index
  logic [CntW-1:0] rd_idx_q;
  logic            rd_pend_q;
  logic [IdxW-1:0] pend_idx_q;
  logic            pend_vld_q;

  // compare unit state
  logic [IdxW-1:0]  best_q, runner_q;
  logic [LoadW-1:0] best_load_q, runner_load_q;
  logic             has_runner_q;

  logic [MaxS-1:0]  valid_q;
  logic [LoadW-1:0] ram_rdata;
  logic [LoadW-1:0] cur_load;
  logic             ram_re, ram_we;

  logic             out_valid_q;
  logic [SrvW-1:0]  assigned_q, next_q;

  logic             in_acc, out_free;
  logic [LoadW:0]   sum;
  logic [LoadW-1:0] sat_load;
  logic [IdxW-1:0]  next_idx;
  logic [IdxW:0]    best_p1, next_p1;

  // effective server count
  always_comb begin
    if (active_q == '0) begin
      n_eff = CntW'(1);
    end else if (32'(active_q) > MaxS) begin
      n_eff = CntW'(MaxS);
    end else begin
      n_eff = CntW'(active_q);
    end
  end

  assign in_stall_o = (state_q != llsd_pkg::StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign ram_re   = (state_q == llsd_pkg::StScan) && (rd_idx_q < n_q);
  assign ram_we   = (state_q == llsd_pkg::StFinish) && out_free &&
                    (action_q == llsd_pkg::ActAssign);
  assign cur_load = pend_vld_q ? ram_rdata : '0;

  llsd_ram #(
    .Width(LoadW),
    .Depth(MaxS)
  ) u_load_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(best_q),
    .wdata_i(sat_load),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q[IdxW-1:0]),
    .rdata_o(ram_rdata)
  );

  // saturating update and next pick from best / runner-up
  assign sum      = {1'b0, best_load_q} + {{(LoadW + 1 - llsd_pkg::JobW){1'b0}}, job_q};
  assign sat_load = sum[LoadW] ? llsd_pkg::LoadMax : sum[LoadW-1:0];

  always_comb begin
    priority if (!has_runner_q) begin
      next_idx = best_q;
    end else if (sat_load < runner_load_q) begin
      next_idx = best_q;
    end else if (sat_load == runner_load_q) begin
      next_idx = (best_q < runner_q) ? best_q : runner_q;
    end else begin
      next_idx = runner_q;
    end
  end

  assign best_p1 = {1'b0, best_q} + 1'b1;
  assign next_p1 = {1'b0, next_idx} + 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      llsd_pkg::StIdle: begin
        if (in_acc) begin
          state_d = (action_i == llsd_pkg::ActAssign) ? llsd_pkg::StScan
                                                      : llsd_pkg::StFinish;
        end
      end
      llsd_pkg::StScan: begin
        if (rd_idx_q == n_q && !rd_pend_q) begin
          state_d = llsd_pkg::StFinish;
        end
      end
      llsd_pkg::StFinish: begin
        if (out_free) begin
          state_d = llsd_pkg::StIdle;
        end
      end
      default: state_d = llsd_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= llsd_pkg::StIdle;
      active_q    <= llsd_pkg::ActiveReset;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        rd_idx_q <= '0;
      end else if (ram_re) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      rd_pend_q <= ram_re;
      // a new result replaces the one taken this cycle, or fills an empty register
      if (state_q == llsd_pkg::StFinish && out_free) begin
        out_valid_q <= 1'b1;
        if (action_q == llsd_pkg::ActClear) begin
          valid_q <= '0;
        end else begin
          valid_q[best_q] <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload: captured item, compare unit, result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q <= action_i;
      job_q    <= job_time_i;
      n_q      <= n_eff;
    end
    if (ram_re) begin
      pend_idx_q <= rd_idx_q[IdxW-1:0];
      pend_vld_q <= valid_q[rd_idx_q[IdxW-1:0]];
    end
    if (rd_pend_q) begin
      if (pend_idx_q == '0) begin
        best_q       <= pend_idx_q;
        best_load_q  <= cur_load;
        has_runner_q <= 1'b0;
      end else if (cur_load < best_load_q) begin
        // old best drops to runner-up
        best_q        <= pend_idx_q;
        best_load_q   <= cur_load;
        runner_q      <= best_q;
        runner_load_q <= best_load_q;
        has_runner_q  <= 1'b1;
      end else if (!has_runner_q || cur_load < runner_load_q) begin
        runner_q      <= pend_idx_q;
        runner_load_q <= cur_load;
        has_runner_q  <= 1'b1;
      end
    end
    if (state_q == llsd_pkg::StFinish && out_free) begin
      if (action_q == llsd_pkg::ActClear) begin
        assigned_q <= '0;
        next_q     <= SrvW'(1);
      end else begin
        assigned_q <= SrvW'(best_p1);
        next_q     <= SrvW'(next_p1);
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign assigned_server_o = assigned_q;
  assign next_server_o     = next_q;

`ifndef SYNTHESIS
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == llsd_pkg::StScan |-> rd_idx_q <= n_q)
    else $error("scan index ran past the server count");

  a_finish_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == llsd_pkg::StFinish && out_free) |=> out_valid_q)
    else $error("finish step did not present a result");

  a_runner_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == llsd_pkg::StFinish && action_q == llsd_pkg::ActAssign && has_runner_q)
      |-> n_q > CntW'(1))
    else $error("runner-up seen with a single server");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != llsd_pkg::StIdle)
    else $error("accepted transaction left the sequencer idle");
`endif

endmodule

@@ rtl/core/llsd_ram.sv @@
// llsd_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module llsd_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]             wdata_i,
  input  logic                         re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]             rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ tb/testbench.sv @@
// testbench: self-checking bench for least_loaded_server_dispatch.
// Depends on llsd_pkg and the dispatcher RTL; holds its own load-tracking predictor and
// a small scoreboard class.
`timescale 1ns / 100ps

module testbench;

  // One expected result transaction.
  typedef struct packed {
    logic [llsd_pkg::SrvW-1:0] assigned;
    logic [llsd_pkg::SrvW-1:0] next_srv;
  } pick_t;

  // Tracks every server's busy time and the active count, and predicts
  // the pick for each accepted request. Results are checked in order.
  class dispatch_scoreboard;
    logic [llsd_pkg::LoadW-1:0] busy [llsd_pkg::MaxServers];
    logic [llsd_pkg::CfgW-1:0]  active_reg;
    pick_t                      expected_picks [$];
    int                         mismatches;
    int                         results_seen;

    function new();
      foreach (busy[i]) busy[i] = '0;
      active_reg   = llsd_pkg::ActiveReset;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_active(input logic [llsd_pkg::CfgW-1:0] v);
      active_reg = v;
    endfunction

    // Least-loaded active server (index from 0), lowest index on ties.
    function int unsigned least_loaded();
      int unsigned n;
      int unsigned best;
      n = 32'(active_reg);
      if (n < 1) n = 1;
      if (n > llsd_pkg::MaxServers) n = llsd_pkg::MaxServers;
      best = 0;
      for (int unsigned i = 1; i < n; i++) begin
        if (busy[i] < busy[best]) best = i;
      end
      return best;
    endfunction

    function void note_request(input logic act, input logic [llsd_pkg::JobW-1:0] jt);
      pick_t                     exp_pick;
      logic [llsd_pkg::LoadW:0]  sum;
      int unsigned               s;
      if (act == llsd_pkg::ActClear) begin
        foreach (busy[i]) busy[i] = '0;
        exp_pick.assigned = '0;
      end else begin
        s   = least_loaded();
        sum = {1'b0, busy[s]} + {{(llsd_pkg::LoadW+1-llsd_pkg::JobW){1'b0}}, jt};
        // saturate rather than wrap
        busy[s] = sum[llsd_pkg::LoadW] ? llsd_pkg::LoadMax : sum[llsd_pkg::LoadW-1:0];
        exp_pick.assigned = llsd_pkg::SrvW'(s + 1);
      end
      exp_pick.next_srv = llsd_pkg::SrvW'(least_loaded() + 1);
      expected_picks.push_back(exp_pick);
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(input logic [llsd_pkg::SrvW-1:0] assigned,
                      input logic [llsd_pkg::SrvW-1:0] next_srv);
      pick_t exp_pick;
      results_seen++;
      if (expected_picks.size() == 0) begin
        report_mismatch($sformatf("unexpected result assigned=%0d next=%0d",
                                  assigned, next_srv));
      end else begin
        exp_pick = expected_picks.pop_front();
        if (assigned !== exp_pick.assigned)
          report_mismatch($sformatf("result %0d: assigned_server %0d, expected %0d",
                                    results_seen, assigned, exp_pick.assigned));
        if (next_srv !== exp_pick.next_srv)
          report_mismatch($sformatf("result %0d: next_server %0d, expected %0d",
                                    results_seen, next_srv, exp_pick.next_srv));
      end
    endtask
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        action_i;
  logic [llsd_pkg::JobW-1:0]   job_time_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [llsd_pkg::SrvW-1:0]   assigned_server_o;
  logic [llsd_pkg::SrvW-1:0]   next_server_o;
  logic                        cfg_we_i;
  logic [llsd_pkg::CfgW-1:0]   cfg_wdata_i;

  dispatch_scoreboard sb = new();

  // Idling controls: sender gaps and receiver stall bursts, per phase.
  bit gaps_on;
  bit stalls_on;
  int jobs;
  int clears;
  int settings;

  least_loaded_server_dispatch u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .job_time_i        (job_time_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .assigned_server_o (assigned_server_o),
    .next_server_o     (next_server_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Safety net: well beyond the slowest legal run (~0.75 ms).
  initial begin
    #(5_000_000);
    $display("Timeout: dispatcher stopped making progress");
    $display("RESULT: ERROR");
    $finish;
  end

  // Result monitor: a transaction moves when valid is high and stall is low.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(assigned_server_o, next_server_o);
  end

  // Receiver: random stall bursts while enabled.
  initial begin
    int unsigned burst;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 16);
        repeat (burst) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Offer one request transaction, optionally after a gap; returns once it
  // has been taken. Valid stays high afterwards so back-to-back items flow.
  task automatic drive_item(input logic act, input logic [llsd_pkg::JobW-1:0] jt);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        action_i   <= 1'($urandom_range(0, 1));
        job_time_i <= llsd_pkg::JobW'($urandom);
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    action_i   <= act;
    job_time_i <= jt;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(act, jt);
    if (act == llsd_pkg::ActClear) clears++;
    else jobs++;
  endtask

  // Drop valid and wait for every outstanding result; every request gives
  // one, so the block is idle once the queue drains.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_active(input logic [llsd_pkg::CfgW-1:0] v);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_active(v);
    settings++;
  endtask

  initial begin
    logic [llsd_pkg::CfgW-1:0] plan [10];
    logic                      act;
    logic [llsd_pkg::JobW-1:0] jt;
    int unsigned               roll;
    int                        k;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = llsd_pkg::ActAssign;
    job_time_i  = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    gaps_on     = 1'b0;
    stalls_on   = 1'b0;
    jobs        = 0;
    clears      = 0;
    settings    = 0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset count of sixteen, ties, extremes of job_time, a clear
    // with a non-zero job_time, zero and over-range counts, and loads kept
    // on servers that drop out of the active set.
    drive_item(llsd_pkg::ActAssign, 16'h0000);
    drive_item(llsd_pkg::ActAssign, 16'hFFFF);
    drive_item(llsd_pkg::ActAssign, 16'h0001);
    drive_item(llsd_pkg::ActAssign, 16'h8000);
    drive_item(llsd_pkg::ActClear,  16'hFFFF);
    write_active(5'd0);
    drive_item(llsd_pkg::ActAssign, 16'h0007);
    drive_item(llsd_pkg::ActAssign, 16'h0003);
    write_active(5'd31);
    drive_item(llsd_pkg::ActAssign, 16'h0002);
    drive_item(llsd_pkg::ActAssign, 16'h5555);
    write_active(5'd17);
    drive_item(llsd_pkg::ActAssign, 16'h0000);
    write_active(5'd3);
    drive_item(llsd_pkg::ActAssign, 16'h001E);
    drive_item(llsd_pkg::ActAssign, 16'h0014);
    drive_item(llsd_pkg::ActAssign, 16'hAAAA);
    write_active(5'd2);
    drive_item(llsd_pkg::ActAssign, 16'h0005);
    write_active(5'd4);
    drive_item(llsd_pkg::ActAssign, 16'h0001);
    drive_item(llsd_pkg::ActAssign, 16'h0001);
    write_active(5'd16);
    drive_item(llsd_pkg::ActClear,  16'h0000);
    drive_item(llsd_pkg::ActAssign, 16'h1234);

    // Random phases, each under its own active count; extremes included.
    plan = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd0, 5'd0, 5'd2, 5'd0, 5'd16};
    plan[5] = llsd_pkg::CfgW'($urandom_range(3, 15));
    plan[6] = llsd_pkg::CfgW'($urandom_range(3, 15));
    plan[8] = llsd_pkg::CfgW'($urandom_range(3, 15));
    for (int ph = 0; ph < 10; ph++) begin
      write_active(plan[ph]);
      // last phase runs flat out
      gaps_on   = (ph != 9) && ($urandom_range(0, 4) != 0);
      stalls_on = (ph != 9) && ($urandom_range(0, 4) != 0);
      repeat (115) begin
        act  = ($urandom_range(0, 24) == 0) ? llsd_pkg::ActClear : llsd_pkg::ActAssign;
        roll = $urandom_range(0, 9);
        // small durations provoke ties; the rest spans the full field
        if (roll < 4)       jt = llsd_pkg::JobW'($urandom_range(0, 15));
        else if (roll == 4) jt = '0;
        else if (roll == 5) jt = '1;
        else                jt = llsd_pkg::JobW'($urandom);
        drive_item(act, jt);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (k = 0; k < 2000 && sb.pending() != 0; k++) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

    $display("Covered %0d job transactions and %0d clears under %0d active-count settings,",
             jobs, clears, settings);
    $display("with ties, job_time extremes and idle bursts; %0d results checked, %0d mismatches.",
             sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
